[design/favr_pkg.sv]
// Shared types and constants of the five-axis velocity ramp.
package favr_pkg;

    localparam int NUM_AXES  = 5;
    localparam int NUM_LIN   = 3;
    localparam int SPEED_W   = 24;
    localparam int REG_W     = 24;
    localparam int FRAC_W    = 16;
    localparam int DT_W      = 16;
    localparam int CFG_IDX_W = 3;

    // 1.0 in Q.32, the ceiling of friction * time step
    localparam logic [39:0] ONE_Q32 = 40'h01_0000_0000;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LIN  = 3'd0,
        CFG_MAX_ANG  = 3'd1,
        CFG_ACC_LIN  = 3'd2,
        CFG_ACC_ANG  = 3'd3,
        CFG_FRIC_LIN = 3'd4,
        CFG_FRIC_ANG = 3'd5,
        CFG_STOP     = 3'd6
    } t_cfg_idx;

    // Register reset values
    localparam logic [REG_W-1:0]  RST_MAX  = 24'd327680;
    localparam logic [REG_W-1:0]  RST_ACC  = 24'd327680;
    localparam logic [REG_W-1:0]  RST_FRIC = 24'd6554;
    localparam logic [FRAC_W-1:0] RST_STOP = 16'd655;

    // Limits one lane works against
    typedef struct packed {
        logic [REG_W-1:0] lim;
        logic [REG_W-1:0] acc;
        logic [REG_W-1:0] fric;
    } t_lane_cfg;

    // Stage enables from the sequencer to every lane
    typedef struct packed {
        logic en_mul;
        logic en_mix;
        logic commit;
    } t_lane_ctl;

endpackage

[design/favr_in_if.sv]
// Input channel: time step and direction requests of one tick.
interface favr_in_if;
    import favr_pkg::*;

    logic            valid;
    logic            ready;
    logic [DT_W-1:0] time_step;
    logic            go_forward;
    logic            go_backward;
    logic            go_left;
    logic            go_right;
    logic            go_up;
    logic            go_down;
    logic            turn_left;
    logic            turn_right;
    logic            tilt_up;
    logic            tilt_down;

    modport source (
        output valid, time_step, go_forward, go_backward, go_left, go_right,
               go_up, go_down, turn_left, turn_right, tilt_up, tilt_down,
        input  ready
    );
    modport sink (
        input  valid, time_step, go_forward, go_backward, go_left, go_right,
               go_up, go_down, turn_left, turn_right, tilt_up, tilt_down,
        output ready
    );
endinterface

[design/favr_out_if.sv]
// Output channel: the five axis speeds after one tick.
interface favr_out_if;
    import favr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_x;
    logic signed [SPEED_W-1:0] speed_y;
    logic signed [SPEED_W-1:0] speed_z;
    logic signed [SPEED_W-1:0] speed_heading;
    logic signed [SPEED_W-1:0] speed_pitch;

    modport source (
        output valid, speed_x, speed_y, speed_z, speed_heading, speed_pitch,
        input  ready
    );
    modport sink (
        input  valid, speed_x, speed_y, speed_z, speed_heading, speed_pitch,
        output ready
    );
endinterface

[design/favr_lane.sv]
// One axis lane: holds the axis speed and computes its next value in three stages.
module favr_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  favr_pkg::t_lane_ctl                 i_ctl,
    input  favr_pkg::t_lane_cfg                 i_cfg,
    input  logic [favr_pkg::FRAC_W-1:0]         i_frac,
    input  logic [favr_pkg::DT_W-1:0]           i_dt,
    input  logic                                i_pos,
    input  logic                                i_neg,
    output logic signed [favr_pkg::SPEED_W-1:0] o_speed
);
    import favr_pkg::*;

    localparam logic signed [26:0] SAT_POS = 27'sd8388607;
    localparam logic signed [26:0] SAT_NEG = -27'sd8388608;

    logic signed [SPEED_W-1:0] r_speed;
    logic signed [SPEED_W-1:0] n_speed;

    // stage 1 products
    logic [39:0] r_acc_dt;
    logic [39:0] r_fric_dt;
    logic [23:0] r_mag;
    logic [47:0] r_mag_sq;
    logic [47:0] r_lim_sq;
    // stage 2 products
    logic [23:0] r_step;
    logic [23:0] r_decay;
    logic [63:0] r_bound;

    logic [23:0] w_mag;
    logic [32:0] w_keep;
    logic [55:0] w_decay_full;
    logic [63:0] w_bound;
    logic        w_stop;
    logic signed [26:0] w_s;
    logic signed [26:0] w_step;
    logic signed [26:0] w_lim;
    logic signed [26:0] w_up;
    logic signed [26:0] w_dn;
    logic signed [26:0] w_dec;
    logic signed [26:0] w_v;

    // Magnitude of the held speed; the most negative value maps to 2^23
    assign w_mag = r_speed[SPEED_W-1] ? (~r_speed + 24'd1) : r_speed;

    // Remaining fraction after friction, floored at zero
    assign w_keep = (r_fric_dt >= ONE_Q32) ? 33'd0
                                           : (ONE_Q32[32:0] - r_fric_dt[32:0]);
    assign w_decay_full = {32'b0, r_mag} * {23'b0, w_keep};
    assign w_bound      = {16'b0, r_lim_sq} * {48'b0, i_frac};

    // Stage 1 and 2 datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_acc_dt  <= {16'b0, i_cfg.acc} * {24'b0, i_dt};
            r_fric_dt <= {16'b0, i_cfg.fric} * {24'b0, i_dt};
            r_mag     <= w_mag;
            r_mag_sq  <= {24'b0, w_mag} * {24'b0, w_mag};
            r_lim_sq  <= {24'b0, i_cfg.lim} * {24'b0, i_cfg.lim};
        end
        if (i_ctl.en_mix) begin
            r_step  <= r_acc_dt[39:16];
            r_decay <= w_decay_full[55:32];
            r_bound <= w_bound;
        end
    end

    // Stage 3: pick the new speed
    assign w_s    = {{3{r_speed[SPEED_W-1]}}, r_speed};
    assign w_step = {3'b0, r_step};
    assign w_lim  = {3'b0, i_cfg.lim};
    assign w_up   = w_s + w_step;
    assign w_dn   = w_s - w_step;
    assign w_dec  = r_speed[SPEED_W-1] ? -{3'b0, r_decay} : {3'b0, r_decay};
    assign w_stop = {r_mag_sq, 16'b0} < r_bound;

    always_comb begin
        if (i_pos && !i_neg) begin
            if (i_cfg.acc == '0) begin
                w_v = w_lim;
            end else begin
                w_v = (w_up > w_lim) ? w_lim : w_up;
            end
        end else if (i_neg && !i_pos) begin
            if (i_cfg.acc == '0) begin
                w_v = -w_lim;
            end else begin
                w_v = (w_dn < -w_lim) ? -w_lim : w_dn;
            end
        end else if (r_speed != '0) begin
            w_v = w_stop ? 27'sd0 : w_dec;
        end else begin
            w_v = 27'sd0;
        end

        // saturate to the output range
        if (w_v > SAT_POS) begin
            n_speed = SAT_POS[SPEED_W-1:0];
        end else if (w_v < SAT_NEG) begin
            n_speed = SAT_NEG[SPEED_W-1:0];
        end else begin
            n_speed = w_v[SPEED_W-1:0];
        end
    end

    // Hold the axis speed; advance it on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
        end else if (i_ctl.commit) begin
            r_speed <= n_speed;
        end
    end

    assign o_speed = r_speed;

endmodule

[design/five_axis_velocity_ramp_core.sv]
// Top level of the five-axis velocity ramp: sequencer, registers, lanes and output merge.
//
// Usage:
//   i_in carries one tick word: a Q0.16 time step and ten direction requests.
//   o_out carries one word per tick: the five updated axis speeds, signed Q7.16.
//   Both channels move a word when valid and ready are high at a rising edge.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
//   write them only while no tick is in flight, which the block does not enforce; an
//   index beyond the register list is ignored.
// Timing:
//   Five lanes, one per axis, run in parallel through three stages (products, decay and
//   stop products, select and saturate). The sequencer steps S_MUL, S_MIX, S_DONE after
//   a tick is accepted, loads the result word on commit in S_DONE and takes a new tick
//   only once back in S_IDLE, so ticks do not overlap.
// Reset and stall:
//   Reset zeroes all speeds, loads the register defaults and empties the
//   output. A finished word waits in the output register; the next tick is
//   still taken and computed, and its commit waits until the word is taken.
module five_axis_velocity_ramp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    favr_in_if.sink                       i_in,
    favr_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [favr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [favr_pkg::REG_W-1:0]    i_cfg_data
);
    import favr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_MIX,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [REG_W-1:0]  r_max_lin;
    logic [REG_W-1:0]  r_max_ang;
    logic [REG_W-1:0]  r_acc_lin;
    logic [REG_W-1:0]  r_acc_ang;
    logic [REG_W-1:0]  r_fric_lin;
    logic [REG_W-1:0]  r_fric_ang;
    logic [FRAC_W-1:0] r_stop;

    // latched tick
    logic [DT_W-1:0]     r_dt;
    logic [NUM_AXES-1:0] r_pos;
    logic [NUM_AXES-1:0] r_neg;

    // output word
    logic                              r_out_valid;
    logic [NUM_AXES-1:0][SPEED_W-1:0]  r_out_speed;

    t_lane_ctl                         w_ctl;
    t_lane_cfg                         w_cfg_lin;
    t_lane_cfg                         w_cfg_ang;
    logic [NUM_AXES-1:0][SPEED_W-1:0]  w_lane_speed;
    logic                              w_accept;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_ctl.en_mul = (r_state == S_MUL);
    assign w_ctl.en_mix = (r_state == S_MIX);
    assign w_ctl.commit = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign w_cfg_lin = '{lim: r_max_lin, acc: r_acc_lin, fric: r_fric_lin};
    assign w_cfg_ang = '{lim: r_max_ang, acc: r_acc_ang, fric: r_fric_ang};

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lin  <= RST_MAX;
            r_max_ang  <= RST_MAX;
            r_acc_lin  <= RST_ACC;
            r_acc_ang  <= RST_ACC;
            r_fric_lin <= RST_FRIC;
            r_fric_ang <= RST_FRIC;
            r_stop     <= RST_STOP;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_LIN:  r_max_lin  <= i_cfg_data;
                CFG_MAX_ANG:  r_max_ang  <= i_cfg_data;
                CFG_ACC_LIN:  r_acc_lin  <= i_cfg_data;
                CFG_ACC_ANG:  r_acc_ang  <= i_cfg_data;
                CFG_FRIC_LIN: r_fric_lin <= i_cfg_data;
                CFG_FRIC_ANG: r_fric_ang <= i_cfg_data;
                CFG_STOP:     r_stop     <= i_cfg_data[FRAC_W-1:0];
                default:      ;
            endcase
        end
    end

    // Latch the tick word; lane order is x, y, z, heading, pitch
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dt  <= i_in.time_step;
            r_pos <= {i_in.tilt_up, i_in.turn_left, i_in.go_up,
                      i_in.go_backward, i_in.go_left};
            r_neg <= {i_in.tilt_down, i_in.turn_right, i_in.go_down,
                      i_in.go_forward, i_in.go_right};
        end
    end

    // Lanes
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        favr_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_cfg   ((g < NUM_LIN) ? w_cfg_lin : w_cfg_ang),
            .i_frac  (r_stop),
            .i_dt    (r_dt),
            .i_pos   (r_pos[g]),
            .i_neg   (r_neg[g]),
            .o_speed (w_lane_speed[g])
        );
    end

    // Sequencer and output merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new word on commit, else drop the word once taken
            if (w_ctl.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_ctl.commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output word payload, loaded from the lane next values on commit
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_merge
        always_ff @(posedge i_clk) begin
            if (w_ctl.commit) begin
                r_out_speed[g] <= g_lane[g].u_lane.n_speed;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.speed_x       = r_out_speed[0];
    assign o_out.speed_y       = r_out_speed[1];
    assign o_out.speed_z       = r_out_speed[2];
    assign o_out.speed_heading = r_out_speed[3];
    assign o_out.speed_pitch   = r_out_speed[4];

    // Lane speeds change only on a commit
    a_speed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(w_ctl.commit) |-> $stable(w_lane_speed))
        else $error("lane speed changed without commit");

    // A commit always presents a word next cycle
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.commit |=> (o_out.valid && r_state == S_IDLE))
        else $error("commit did not present an output word");

    // A new output word only follows the final lane stage
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_DONE))
        else $error("output word appeared outside the final stage");

    // An accepted tick always starts the product stage
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MUL))
        else $error("accepted tick did not start the lanes");

endmodule

[bench/five_axis_velocity_ramp_core_tb.sv]
// Testbench of the five-axis velocity ramp core: directed and random ticks, predicted speeds.
module five_axis_velocity_ramp_core_tb;
    import favr_pkg::*;

    typedef logic [63:0]               t_u64;
    typedef logic signed [SPEED_W-1:0] t_speed;

    typedef struct packed {
        logic [DT_W-1:0] time_step;
        logic            go_forward;
        logic            go_backward;
        logic            go_left;
        logic            go_right;
        logic            go_up;
        logic            go_down;
        logic            turn_left;
        logic            turn_right;
        logic            tilt_up;
        logic            tilt_down;
    } t_tick;

    typedef struct packed {
        t_speed x;
        t_speed y;
        t_speed z;
        t_speed heading;
        t_speed pitch;
    } t_speeds;

    // Request pattern on one axis
    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_POS,
        DIR_NEG,
        DIR_BOTH
    } t_dir;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam longint SPEED_TOP     = 8388607;
    localparam longint SPEED_BOTTOM  = -8388608;
    localparam int     LONG_HOLD     = 300;
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_TICKS   = 100;
    localparam int     SETTLE_CYCLES = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0]     i_cfg_data;

    favr_in_if  tick_ch ();
    favr_out_if speed_ch ();

    five_axis_velocity_ramp_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_ch),
        .o_out      (speed_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predicted speeds and register copies
    t_speeds          vel;
    logic [REG_W-1:0] lim_lin, lim_ang, acc_lin, acc_ang, fric_lin, fric_ang;
    logic [FRAC_W-1:0] stop_frac;

    t_tick   pending_ticks[$];
    t_speeds expected_speeds[$];
    t_tick   cur_tick;
    t_tick   tick_word;
    t_speeds want;
    bit      offering;
    bit      send_idle;
    bit      recv_idle;
    int      send_gap;
    int      recv_hold;
    int      words_seen;
    int      mismatches;

    // Random request runs per axis
    t_dir axis_dir[NUM_AXES];
    int   axis_run[NUM_AXES];

    assign {tick_ch.time_step, tick_ch.go_forward, tick_ch.go_backward, tick_ch.go_left,
            tick_ch.go_right, tick_ch.go_up, tick_ch.go_down, tick_ch.turn_left,
            tick_ch.turn_right, tick_ch.tilt_up, tick_ch.tilt_down} = tick_word;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // One axis over one tick: ramp, clamp, stop test or decay, then saturate
    function automatic t_speed step_axis(t_speed spd, logic up, logic dn,
                                         logic [REG_W-1:0] lim, logic [REG_W-1:0] acc,
                                         logic [REG_W-1:0] fric, logic [FRAC_W-1:0] frac,
                                         logic [DT_W-1:0] dt);
        longint nxt;
        longint top;
        t_u64   gain;
        t_u64   mag;
        t_u64   sq;
        t_u64   bound;
        t_u64   drag;
        t_u64   keep;
        top  = longint'(t_u64'(lim));
        gain = (t_u64'(acc) * t_u64'(dt)) >> 16;
        mag  = (spd < 0) ? t_u64'(-longint'(spd)) : t_u64'(spd);
        if (up && !dn) begin
            if (acc == '0) begin
                nxt = top;
            end else begin
                nxt = longint'(spd) + longint'(gain);
                if (nxt > top) nxt = top;
            end
        end else if (dn && !up) begin
            if (acc == '0) begin
                nxt = -top;
            end else begin
                nxt = longint'(spd) - longint'(gain);
                if (nxt < -top) nxt = -top;
            end
        end else if (spd != 0) begin
            sq    = (mag * mag) << 16;
            bound = t_u64'(lim) * t_u64'(lim) * t_u64'(frac);
            if (sq < bound) begin
                nxt = 0;
            end else begin
                // keep = 1 - min(1, friction * dt), truncate the magnitude
                drag = t_u64'(fric) * t_u64'(dt);
                if (drag > ONE_Q32) drag = ONE_Q32;
                keep = ONE_Q32 - drag;
                mag  = (mag * keep) >> 32;
                nxt  = (spd < 0) ? -longint'(mag) : longint'(mag);
            end
        end else begin
            nxt = 0;
        end
        if (nxt > SPEED_TOP) nxt = SPEED_TOP;
        else if (nxt < SPEED_BOTTOM) nxt = SPEED_BOTTOM;
        return nxt[SPEED_W-1:0];
    endfunction

    // Advance all five speeds by one tick and return the new word
    function automatic t_speeds advance_speeds(t_tick t);
        vel.x = step_axis(vel.x, t.go_left, t.go_right, lim_lin, acc_lin, fric_lin,
                          stop_frac, t.time_step);
        vel.y = step_axis(vel.y, t.go_backward, t.go_forward, lim_lin, acc_lin, fric_lin,
                          stop_frac, t.time_step);
        vel.z = step_axis(vel.z, t.go_up, t.go_down, lim_lin, acc_lin, fric_lin,
                          stop_frac, t.time_step);
        vel.heading = step_axis(vel.heading, t.turn_left, t.turn_right, lim_ang, acc_ang,
                                fric_ang, stop_frac, t.time_step);
        vel.pitch = step_axis(vel.pitch, t.tilt_up, t.tilt_down, lim_ang, acc_ang,
                              fric_ang, stop_frac, t.time_step);
        return vel;
    endfunction

    function automatic logic [1:0] dir_bits(t_dir d);
        case (d)
            DIR_POS:  return 2'b10;
            DIR_NEG:  return 2'b01;
            DIR_BOTH: return 2'b11;
            default:  return 2'b00;
        endcase
    endfunction

    function automatic void check_axis(string axis, t_speed exp_val, t_speed got_val);
        if (exp_val !== got_val) begin
            mismatches++;
            $display("%0t: %s speed expected %0d, got %0d", $time, axis, exp_val, got_val);
        end
    endfunction

    // Range of values for a Q8.16 register, extremes included
    function automatic logic [REG_W-1:0] pick_rate();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return REG_W'($urandom);
            default: return REG_W'($urandom_range(32'h2000, 32'hA0000));
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2, 3:    return DT_W'($urandom_range(0, 1023));
            default: return DT_W'($urandom);
        endcase
    endfunction

    task automatic push_tick(logic [DT_W-1:0] dt, t_dir dx, t_dir dy, t_dir dz,
                             t_dir dh, t_dir dp);
        t_tick t;
        t.time_step = dt;
        {t.go_left, t.go_right}     = dir_bits(dx);
        {t.go_backward, t.go_forward} = dir_bits(dy);
        {t.go_up, t.go_down}        = dir_bits(dz);
        {t.turn_left, t.turn_right} = dir_bits(dh);
        {t.tilt_up, t.tilt_down}    = dir_bits(dp);
        pending_ticks.push_back(t);
    endtask

    // Mostly held request runs so ramps reach the limit and coasts reach a stop
    task automatic push_random_ticks(int count);
        t_tick t;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                t = $bits(t_tick)'($urandom);
                pending_ticks.push_back(t);
            end else begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (axis_run[a] == 0) begin
                        axis_dir[a] = t_dir'($urandom_range(0, 3));
                        axis_run[a] = $urandom_range(1, 12);
                    end
                    axis_run[a]--;
                end
                push_tick(pick_dt(), axis_dir[0], axis_dir[1], axis_dir[2], axis_dir[3],
                          axis_dir[4]);
            end
        end
    endtask

    // Hold until every tick is taken and every word has come back
    task automatic wait_idle();
        while (pending_ticks.size() != 0 || offering || expected_speeds.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_MAX_LIN:  lim_lin   = data;
            CFG_MAX_ANG:  lim_ang   = data;
            CFG_ACC_LIN:  acc_lin   = data;
            CFG_ACC_ANG:  acc_ang   = data;
            CFG_FRIC_LIN: fric_lin  = data;
            CFG_FRIC_ANG: fric_ang  = data;
            CFG_STOP:     stop_frac = data[FRAC_W-1:0];
            default:      ;
        endcase
    endtask

    // Write all registers, then a write to the unused index that must be dropped
    task automatic load_config(logic [REG_W-1:0] ml, logic [REG_W-1:0] ma,
                               logic [REG_W-1:0] al, logic [REG_W-1:0] aa,
                               logic [REG_W-1:0] fl, logic [REG_W-1:0] fa,
                               logic [REG_W-1:0] stop_raw);
        write_reg(CFG_MAX_LIN, ml);
        write_reg(CFG_MAX_ANG, ma);
        write_reg(CFG_ACC_LIN, al);
        write_reg(CFG_ACC_ANG, aa);
        write_reg(CFG_FRIC_LIN, fl);
        write_reg(CFG_FRIC_ANG, fa);
        write_reg(CFG_STOP, stop_raw);
        write_reg(CFG_UNUSED, REG_W'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer pending ticks and predict each accepted one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (tick_ch.valid && tick_ch.ready) begin
                expected_speeds.push_back(advance_speeds(cur_tick));
                offering = 1'b0;
                send_gap = send_idle ? $urandom_range(0, 16) : 0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ticks.size() != 0) begin
                    cur_tick = pending_ticks.pop_front();
                    offering = 1'b1;
                end
            end
            tick_ch.valid <= offering;
            tick_word     <= cur_tick;
        end
    end

    // Take speed words, compare with the oldest prediction, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (speed_ch.valid && speed_ch.ready) begin
                if (expected_speeds.size() == 0) begin
                    mismatches++;
                    $display("%0t: speed word with none expected, got %0d %0d %0d %0d %0d",
                             $time, speed_ch.speed_x, speed_ch.speed_y, speed_ch.speed_z,
                             speed_ch.speed_heading, speed_ch.speed_pitch);
                end else begin
                    want = expected_speeds.pop_front();
                    check_axis("x", want.x, speed_ch.speed_x);
                    check_axis("y", want.y, speed_ch.speed_y);
                    check_axis("z", want.z, speed_ch.speed_z);
                    check_axis("heading", want.heading, speed_ch.speed_heading);
                    check_axis("pitch", want.pitch, speed_ch.speed_pitch);
                end
                words_seen++;
                recv_hold = recv_idle ? $urandom_range(0, 16) : 0;
                // long hold-off so the core backs up into its input
                if (words_seen == 60 || words_seen == 450) recv_hold = LONG_HOLD;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                speed_ch.ready <= 1'b0;
            end else begin
                speed_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_MAX_LIN;
        i_cfg_data     = '0;
        tick_ch.valid  = 1'b0;
        speed_ch.ready = 1'b0;
        tick_word      = '0;
        cur_tick       = '0;
        offering       = 1'b0;
        send_idle      = 1'b0;
        recv_idle      = 1'b0;
        send_gap       = 0;
        recv_hold      = 0;
        words_seen     = 0;
        mismatches     = 0;
        vel            = '0;
        lim_lin        = RST_MAX;
        lim_ang        = RST_MAX;
        acc_lin        = RST_ACC;
        acc_ang        = RST_ACC;
        fric_lin       = RST_FRIC;
        fric_ang       = RST_FRIC;
        stop_frac      = RST_STOP;
        for (int a = 0; a < NUM_AXES; a++) begin
            axis_dir[a] = DIR_NONE;
            axis_run[a] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: idle at zero, ramp to the limit, coast, zero step, reverse
        push_tick('1, DIR_NONE, DIR_NONE, DIR_NONE, DIR_NONE, DIR_NONE);
        push_tick('1, DIR_POS, DIR_NEG, DIR_POS, DIR_POS, DIR_NEG);
        push_tick('1, DIR_POS, DIR_NEG, DIR_POS, DIR_POS, DIR_NEG);
        push_tick('1, DIR_NONE, DIR_BOTH, DIR_NONE, DIR_BOTH, DIR_NONE);
        push_tick('0, DIR_NEG, DIR_POS, DIR_NEG, DIR_NEG, DIR_POS);
        push_tick('1, DIR_NEG, DIR_POS, DIR_NEG, DIR_NEG, DIR_POS);
        wait_idle();

        // Limit beyond the output range with instant accel: saturate both ways
        load_config('1, '1, '0, '0, '0, '0, '0);
        push_tick(16'd1, DIR_POS, DIR_NEG, DIR_POS, DIR_POS, DIR_NEG);
        push_tick(16'd1, DIR_NEG, DIR_POS, DIR_NEG, DIR_NEG, DIR_POS);
        push_tick('1, DIR_NONE, DIR_BOTH, DIR_NONE, DIR_BOTH, DIR_NONE);
        wait_idle();

        // Speeds beyond the limit against the request, zero angular limit,
        // friction past one, full stop fraction
        load_config(24'd327680, '0, 24'd65536, '1, '1, '0, '1);
        push_tick('1, DIR_POS, DIR_NEG, DIR_NONE, DIR_NONE, DIR_NONE);
        push_tick('1, DIR_NEG, DIR_POS, DIR_NONE, DIR_POS, DIR_NEG);
        push_tick('1, DIR_BOTH, DIR_BOTH, DIR_NONE, DIR_NONE, DIR_NONE);
        push_tick(16'h0400, DIR_POS, DIR_NONE, DIR_NONE, DIR_NONE, DIR_NONE);
        push_tick('1, DIR_NONE, DIR_NONE, DIR_NONE, DIR_NONE, DIR_NONE);
        wait_idle();

        // Random phases over varied settings and idling on either side
        for (int k = 0; k < RANDOM_PHASES; k++) begin
            if (k == 0)
                load_config(RST_MAX, RST_MAX, RST_ACC, RST_ACC, RST_FRIC, RST_FRIC,
                            REG_W'(RST_STOP));
            else
                load_config(pick_rate(), pick_rate(), pick_rate(), pick_rate(),
                            pick_rate(), pick_rate(), REG_W'($urandom));
            send_idle = k[0];
            recv_idle = k[1];
            if (k == 3) begin
                // sender pauses until every word is back
                push_random_ticks(PHASE_TICKS / 2);
                wait_idle();
                push_random_ticks(PHASE_TICKS / 2);
            end else begin
                push_random_ticks(PHASE_TICKS);
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Drop the run if it hangs
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
